// ===== rtl/bmoa_pkg.sv =====
`timescale 1ns / 1ps
package bmoa_pkg;

    localparam int DEF_NUM_BUCKETS  = 8;
    localparam int DEF_BUCKET_SLOTS = 256;
    localparam int ADDR_W           = 48;
    localparam int WORD_W           = 64;
    localparam int PADDR_W          = 5;
    localparam int PDATA_W          = 64;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OOM       = 2'd1;
    localparam logic [1:0] ST_NOT_OWNED = 2'd2;
    localparam logic [1:0] ST_DBL_FREE  = 2'd3;

    localparam logic [1:0] REG_REGION_BASE = 2'd0;
    localparam logic [1:0] REG_STRIDE      = 2'd1;
    localparam logic [1:0] REG_OBJ_SIZE    = 2'd2;
    localparam logic [1:0] REG_CAPACITY    = 2'd3;

    localparam logic [47:0] RST_REGION_BASE = 48'd0;
    localparam logic [31:0] RST_STRIDE      = 32'd16384;
    localparam logic [15:0] RST_OBJ_SIZE    = 16'd64;
    localparam logic [8:0]  RST_CAPACITY    = 9'd256;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [47:0] object_address;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] result_address;
        logic        is_owned;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ASRCH,
        S_ACLR,
        S_ARD,
        S_ASCAN,
        S_AMUL,
        S_AADD,
        S_OWN,
        S_DIV,
        S_FIDX,
        S_FRD,
        S_FCHK,
        S_OUT
    } t_state;

endpackage

// ===== rtl/bitmap_object_allocator.sv =====
`timescale 1ns / 1ps
// bitmap object allocator
// input channel: i_in_valid / o_in_stall with i_in_item (request type, address).
// output channel: o_out_valid / i_out_stall with o_out_item (status, address, owned).
// one result item for every request item; one request is worked on at a time.
// alloc walks the open buckets for one below capacity, opens a new bucket
// (clearing its bitmap word by word) when none fits, and scans the bitmap
// words for the lowest free slot; query and free walk the buckets for the
// owner, and free then divides the offset by the object size, one quotient
// bit a step; the single-port bitmap memory gives one 64-bit word per access.
// a finished result sits in an output register, so the next request is taken
// while the receiver stalls; if a second result is ready before the first is
// taken the block waits. config registers sit on an apb port (8 bytes apart).
// reset clears the config registers to their defaults, drops all buckets and
// zeroes the used counts; bitmaps are cleared when a bucket is opened.
module bitmap_object_allocator #(
    parameter int NUM_BUCKETS  = bmoa_pkg::DEF_NUM_BUCKETS,
    parameter int BUCKET_SLOTS = bmoa_pkg::DEF_BUCKET_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bmoa_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bmoa_pkg::t_out_item           o_out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bmoa_pkg::PADDR_W-1:0]  paddr,
    input  logic [bmoa_pkg::PDATA_W-1:0]  pwdata,
    output logic [bmoa_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import bmoa_pkg::*;

    localparam int WORDS = (BUCKET_SLOTS + WORD_W - 1) / WORD_W;
    localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BIW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int BW    = $clog2(NUM_BUCKETS + 1);
    localparam int CW    = $clog2(BUCKET_SLOTS + 1);
    localparam int EW    = (CW > 9) ? CW : 9;
    localparam int SIW   = WIW + 6;
    localparam int KW    = ((SIW > CW) ? SIW : CW) + 1;
    localparam int OW    = CW + 16;
    localparam int DCW   = $clog2(OW + 1);
    localparam int AW    = BIW + WIW;
    localparam int DEPTH = 2 ** AW;

    t_state r_state, n_state;

    logic [47:0] r_cfg_base;
    logic [31:0] r_cfg_stride;
    logic [15:0] r_cfg_size;
    logic [8:0]  r_cfg_cap;

    logic [CW-1:0]   r_used [NUM_BUCKETS];
    logic [BW-1:0]   r_active;
    logic [BW-1:0]   r_bkt;
    logic [47:0]     r_base;
    logic [WIW-1:0]  r_word;
    logic [SIW-1:0]  r_slot;
    logic [1:0]      r_req;
    logic [47:0]     r_addr;
    logic [OW-1:0]   r_span;
    logic [15:0]     r_rem;
    logic [OW-1:0]   r_quo;
    logic [DCW-1:0]  r_dcnt;
    logic [SIW+15:0] r_prod;
    logic [1:0]      r_status;
    logic [47:0]     r_raddr;
    logic            r_owned;
    logic            r_ovalid;
    t_out_item       r_oitem;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;
    logic              mem_we;
    logic [WORD_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_addr;

    logic [EW-1:0]     cap_x;
    logic [CW-1:0]     eff_cap;
    logic [WORD_W-1:0] masked;
    logic              zero_found;
    logic [5:0]        zero_idx;
    logic              own_hit;
    logic [47:0]       offset;
    logic [16:0]       rem_sh;
    logic              div_ge;
    logic [16:0]       rem_sub;
    logic [BIW-1:0]    bidx;
    logic              in_acc;
    logic              cfg_wr;
    logic              word_last;
    logic              bkt_open;
    logic              fits;

    assign pready     = 1'b1;
    assign cfg_wr     = psel & penable & pwrite;
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_oitem;
    assign bidx       = r_bkt[BIW-1:0];
    assign mem_addr   = {bidx, r_word};
    assign word_last  = (r_word == WIW'(WORDS - 1));
    assign bkt_open   = (r_bkt < r_active);
    assign fits       = (r_used[bidx] < eff_cap);

    always_comb begin
        unique case (paddr[4:3])
            REG_REGION_BASE: prdata = PDATA_W'(r_cfg_base);
            REG_STRIDE:      prdata = PDATA_W'(r_cfg_stride);
            REG_OBJ_SIZE:    prdata = PDATA_W'(r_cfg_size);
            REG_CAPACITY:    prdata = PDATA_W'(r_cfg_cap);
            default:         prdata = '0;
        endcase
    end

    // out-of-range capacity is pinned to 1 .. BUCKET_SLOTS
    always_comb begin
        cap_x = EW'(r_cfg_cap);
        if (cap_x == '0) begin
            cap_x = EW'(1);
        end else if (cap_x > EW'(BUCKET_SLOTS)) begin
            cap_x = EW'(BUCKET_SLOTS);
        end
        eff_cap = cap_x[CW-1:0];
    end

    // lowest free slot of the current word; slots at or past capacity count as used
    always_comb begin
        zero_found = 1'b0;
        zero_idx   = '0;
        for (int k = 0; k < WORD_W; k++) begin
            masked[k] = r_rdata[k] | (KW'({r_word, 6'(k)}) >= KW'(eff_cap));
        end
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (!masked[k]) begin
                zero_found = 1'b1;
                zero_idx   = 6'(k);
            end
        end
    end

    // range end is not wrapped
    assign own_hit = ({1'b0, r_addr} >= {1'b0, r_base}) &&
                     ({1'b0, r_addr} < ({1'b0, r_base} + 49'(r_span)));
    assign offset  = r_addr - r_base;
    assign rem_sh  = {r_rem, r_quo[OW-1]};
    assign div_ge  = (rem_sh >= {1'b0, r_cfg_size});
    assign rem_sub = rem_sh - {1'b0, r_cfg_size};

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_wdata = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    priority case (i_in_item.req_type)
                        REQ_ALLOC: n_state = S_ASRCH;
                        REQ_CLEAR: n_state = S_OUT;
                        default:   n_state = S_OWN;
                    endcase
                end
            end
            S_ASRCH: begin
                if (bkt_open) begin
                    if (fits) n_state = S_ARD;
                end else if (r_active < BW'(NUM_BUCKETS)) begin
                    n_state = S_ACLR;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_ACLR: begin
                mem_we = 1'b1;
                if (word_last) n_state = S_ARD;
            end
            S_ARD: n_state = S_ASCAN;
            S_ASCAN: begin
                if (zero_found) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rdata | (WORD_W'(1) << zero_idx);
                    n_state   = S_AMUL;
                end else if (word_last) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_ARD;
                end
            end
            S_AMUL: n_state = S_AADD;
            S_AADD: n_state = S_OUT;
            S_OWN: begin
                if (bkt_open) begin
                    if (own_hit) n_state = (r_req == REQ_QUERY) ? S_OUT : S_DIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV: if (r_dcnt == DCW'(OW - 1)) n_state = S_FIDX;
            S_FIDX: n_state = S_FRD;
            S_FRD: n_state = S_FCHK;
            S_FCHK: begin
                if (r_rdata[r_slot[5:0]]) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rdata & ~(WORD_W'(1) << r_slot[5:0]);
                end
                n_state = S_OUT;
            end
            S_OUT: if (!r_ovalid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        r_rdata <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base   <= RST_REGION_BASE;
            r_cfg_stride <= RST_STRIDE;
            r_cfg_size   <= RST_OBJ_SIZE;
            r_cfg_cap    <= RST_CAPACITY;
        end else if (cfg_wr) begin
            unique case (paddr[4:3])
                REG_REGION_BASE: r_cfg_base   <= pwdata[47:0];
                REG_STRIDE:      r_cfg_stride <= pwdata[31:0];
                REG_OBJ_SIZE:    r_cfg_size   <= pwdata[15:0];
                REG_CAPACITY:    r_cfg_cap    <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_span <= OW'(eff_cap * r_cfg_size);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_ovalid <= 1'b0;
            for (int b = 0; b < NUM_BUCKETS; b++) r_used[b] <= '0;
        end else begin
            // the output register reloads in S_OUT, so only drain it elsewhere
            if (r_ovalid && !i_out_stall && (r_state != S_OUT)) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_req    <= i_in_item.req_type;
                        r_addr   <= i_in_item.object_address;
                        r_bkt    <= '0;
                        r_base   <= r_cfg_base;
                        r_word   <= '0;
                        r_status <= ST_OK;
                        r_raddr  <= '0;
                        r_owned  <= 1'b0;
                        if (i_in_item.req_type == REQ_CLEAR) r_active <= '0;
                    end
                end
                S_ASRCH: begin
                    if (bkt_open) begin
                        if (!fits) begin
                            r_bkt  <= r_bkt + 1'b1;
                            r_base <= r_base + 48'(r_cfg_stride);
                        end
                    end else if (r_active < BW'(NUM_BUCKETS)) begin
                        r_used[bidx] <= '0;
                        r_active     <= r_active + 1'b1;
                        r_word       <= '0;
                    end else begin
                        r_status <= ST_OOM;
                    end
                end
                S_ACLR: r_word <= word_last ? '0 : r_word + 1'b1;
                S_ASCAN: begin
                    if (zero_found) begin
                        r_slot       <= {r_word, zero_idx};
                        r_used[bidx] <= r_used[bidx] + 1'b1;
                    end else if (word_last) begin
                        r_status <= ST_OOM;
                    end else begin
                        r_word <= r_word + 1'b1;
                    end
                end
                S_AMUL: r_prod <= r_slot * r_cfg_size;
                S_AADD: r_raddr <= r_base + 48'(r_prod);
                S_OWN: begin
                    if (bkt_open) begin
                        if (own_hit) begin
                            r_owned <= (r_req == REQ_QUERY);
                            r_rem   <= '0;
                            r_quo   <= offset[OW-1:0];
                            r_dcnt  <= '0;
                        end else begin
                            r_bkt  <= r_bkt + 1'b1;
                            r_base <= r_base + 48'(r_cfg_stride);
                        end
                    end else if (r_req == REQ_FREE) begin
                        r_status <= ST_NOT_OWNED;
                    end
                end
                // restoring divide, one quotient bit a step
                S_DIV: begin
                    r_rem  <= div_ge ? rem_sub[15:0] : rem_sh[15:0];
                    r_quo  <= {r_quo[OW-2:0], div_ge};
                    r_dcnt <= r_dcnt + 1'b1;
                end
                S_FIDX: begin
                    r_slot <= r_quo[SIW-1:0];
                    r_word <= r_quo[SIW-1:6];
                end
                S_FCHK: begin
                    if (!r_rdata[r_slot[5:0]]) begin
                        r_status <= ST_DBL_FREE;
                    end else if (r_used[bidx] != '0) begin
                        r_used[bidx] <= r_used[bidx] - 1'b1;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_ovalid                <= 1'b1;
                        r_oitem.status          <= r_status;
                        r_oitem.result_address  <= r_raddr;
                        r_oitem.is_owned        <= r_owned;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/bmoa_checker.sv =====
`timescale 1ns / 1ps
module bmoa_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input bmoa_pkg::t_out_item o_out_item,
    input logic                pready
);
    import bmoa_pkg::*;

    // a result waiting on a stalled receiver stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // one request at a time: an accepted item closes the input
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item accepted while busy");

    a_addr_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != ST_OK) |-> (o_out_item.result_address == '0))
        else $error("address returned with failing status");

    a_owned_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.is_owned |->
            (o_out_item.status == ST_OK) && (o_out_item.result_address == '0))
        else $error("owned flag with bad status or address");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("config port not ready");

endmodule

bind bitmap_object_allocator bmoa_checker u_bmoa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item),
    .pready      (pready)
);

// ===== dv/bitmap_object_allocator_tb.sv =====
`timescale 1ns / 1ps
module bitmap_object_allocator_tb;
    import bmoa_pkg::*;

    localparam int NB = DEF_NUM_BUCKETS;
    localparam int NS = DEF_BUCKET_SLOTS;
    localparam logic [63:0] AMASK = 64'hFFFF_FFFF_FFFF;
    localparam int WDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in_item i_in_item;
    logic o_out_valid;
    logic i_out_stall;
    t_out_item o_out_item;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    bitmap_object_allocator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // allocator shadow state and config
    logic [47:0] cfg_base;
    logic [31:0] cfg_stride;
    logic [15:0] cfg_osz;
    logic [8:0]  cfg_cap;
    logic [NS-1:0] slot_map [NB];
    int used_cnt [NB];
    int n_active;

    t_in_item  req_q [$];
    t_out_item result_q [$];
    int n_errors = 0;
    // items taken off the queue whose result has not been checked yet
    int n_pending = 0;
    bit no_idle = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_cnt = 0;
    int wdog = 0;

    function automatic int eff_cap();
        if (cfg_cap == 0) return 1;
        if (cfg_cap > NS) return NS;
        return int'(cfg_cap);
    endfunction

    function automatic logic [63:0] bucket_base(int b);
        return (64'(cfg_base) + 64'(b) * 64'(cfg_stride)) & AMASK;
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic int owner_of(logic [63:0] a);
        logic [63:0] span;
        logic [63:0] bb;
        span = 64'(eff_cap()) * 64'(cfg_osz);
        for (int b = 0; b < n_active && b < NB; b++) begin
            bb = bucket_base(b);
            if (a >= bb && a < bb + span) return b;
        end
        return -1;
    endfunction

    function automatic t_out_item alloc_step(t_in_item rq);
        t_out_item r;
        int sel;
        int cap;
        int own;
        logic [63:0] a;
        logic [63:0] idx;
        r = '0;
        cap = eff_cap();
        a = 64'(rq.object_address);
        case (rq.req_type)
            REQ_ALLOC: begin
                sel = -1;
                for (int b = 0; b < n_active && b < NB; b++) begin
                    if (sel < 0 && used_cnt[b] < cap) sel = b;
                end
                if (sel < 0 && n_active < NB) begin
                    sel = n_active;
                    slot_map[sel] = '0;
                    used_cnt[sel] = 0;
                    n_active++;
                end
                r.status = ST_OOM;
                if (sel >= 0) begin
                    for (int i = 0; i < cap; i++) begin
                        if (r.status == ST_OOM && !slot_map[sel][i]) begin
                            slot_map[sel][i] = 1'b1;
                            used_cnt[sel]++;
                            r.result_address = 48'((bucket_base(sel)
                                + 64'(i) * 64'(cfg_osz)) & AMASK);
                            r.status = ST_OK;
                        end
                    end
                end
            end
            REQ_FREE: begin
                own = owner_of(a);
                if (own < 0 || cfg_osz == 0) begin
                    r.status = ST_NOT_OWNED;
                end else begin
                    idx = (a - bucket_base(own)) / 64'(cfg_osz);
                    if (idx >= 64'(cap)) r.status = ST_NOT_OWNED;
                    else if (!slot_map[own][idx]) r.status = ST_DBL_FREE;
                    else begin
                        slot_map[own][idx] = 1'b0;
                        if (used_cnt[own] > 0) used_cnt[own]--;
                    end
                end
            end
            REQ_QUERY: r.is_owned = (owner_of(a) >= 0);
            default: n_active = 0;
        endcase
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (req_q.size() > 0 && (no_idle || $urandom_range(99) >= 32)) begin
                i_in_valid <= 1'b1;
                i_in_item <= req_q.pop_front();
                n_pending++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with a long hold when requested
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_cnt <= 400;
            i_out_stall <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !no_idle && ($urandom_range(99) < 32);
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) result_q.push_back(alloc_step(i_in_item));
            if (o_out_valid && !i_out_stall) begin
                if (n_pending > 0) n_pending--;
                if (result_q.size() == 0) begin
                    $error("result with nothing expected");
                    n_errors++;
                end else begin
                    e = result_q.pop_front();
                    if (o_out_item.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_out_item.status);
                        n_errors++;
                    end
                    if (o_out_item.result_address !== e.result_address) begin
                        $error("result_address exp %h got %h", e.result_address,
                               o_out_item.result_address);
                        n_errors++;
                    end
                    if (o_out_item.is_owned !== e.is_owned) begin
                        $error("is_owned exp %0d got %0d", e.is_owned, o_out_item.is_owned);
                        n_errors++;
                    end
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) wdog <= 0;
            else if (req_q.size() > 0 || result_q.size() > 0 || i_in_valid
                     || n_pending > 0) begin
                wdog <= wdog + 1;
                if (wdog >= WDOG_LIMIT) begin
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(idx) << 3;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_REGION_BASE: cfg_base = val[47:0];
            REG_STRIDE:      cfg_stride = val[31:0];
            REG_OBJ_SIZE:    cfg_osz = val[15:0];
            default:         cfg_cap = val[8:0];
        endcase
    endtask

    task automatic set_cfg(logic [47:0] b, logic [31:0] s, logic [15:0] o, logic [8:0] c);
        apb_write(REG_REGION_BASE, 64'(b));
        apb_write(REG_STRIDE, 64'(s));
        apb_write(REG_OBJ_SIZE, 64'(o));
        apb_write(REG_CAPACITY, 64'(c));
    endtask

    task automatic wait_drained();
        while (req_q.size() > 0 || n_pending > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_in_item mk_req(logic [1:0] t, logic [47:0] a);
        t_in_item r;
        r.req_type = t;
        r.object_address = a;
        return r;
    endfunction

    // mostly addresses near slot boundaries of buckets 0 to NB
    function automatic logic [47:0] pick_addr();
        int r;
        logic [63:0] a;
        r = $urandom_range(9);
        if (r == 0) return rand48();
        a = bucket_base($urandom_range(NB)) + 64'($urandom_range(eff_cap()))
            * 64'(cfg_osz);
        if (r == 1) a = a + 64'($urandom_range(int'(cfg_osz)));
        return a[47:0];
    endfunction

    task automatic push_random(int n);
        int r;
        logic [1:0] t;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            t = (r < 45) ? REQ_ALLOC : (r < 77) ? REQ_FREE : (r < 97) ? REQ_QUERY
                : REQ_CLEAR;
            req_q.push_back(mk_req(t, pick_addr()));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_base = RST_REGION_BASE;
        cfg_stride = RST_STRIDE;
        cfg_osz = RST_OBJ_SIZE;
        cfg_cap = RST_CAPACITY;
        n_active = 0;
        for (int b = 0; b < NB; b++) begin
            slot_map[b] = '0;
            used_cnt[b] = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset config
        req_q.push_back(mk_req(REQ_QUERY, 48'd0));
        req_q.push_back(mk_req(REQ_FREE, 48'd0));
        req_q.push_back(mk_req(REQ_ALLOC, 48'hFFFF_FFFF_FFFF));
        req_q.push_back(mk_req(REQ_ALLOC, 48'd0));
        req_q.push_back(mk_req(REQ_QUERY, 48'd64));
        req_q.push_back(mk_req(REQ_QUERY, 48'd16383));
        req_q.push_back(mk_req(REQ_QUERY, 48'hFFFF_FFFF_FFFF));
        req_q.push_back(mk_req(REQ_FREE, 48'd65));
        req_q.push_back(mk_req(REQ_FREE, 48'd64));
        req_q.push_back(mk_req(REQ_FREE, 48'hFFFF_FFFF_FFFF));
        req_q.push_back(mk_req(REQ_ALLOC, 48'd0));
        req_q.push_back(mk_req(REQ_CLEAR, 48'h5555_5555_5555));
        req_q.push_back(mk_req(REQ_QUERY, 48'd0));
        req_q.push_back(mk_req(REQ_ALLOC, 48'hAAAA_AAAA_AAAA));
        req_q.push_back(mk_req(REQ_FREE, 48'd0));
        req_q.push_back(mk_req(REQ_FREE, 48'd0));
        wait_drained();

        // tiny buckets: out of memory, then frees and reuse
        set_cfg(48'h1000, 32'd64, 16'd16, 9'd3);
        for (int k = 0; k < 26; k++) req_q.push_back(mk_req(REQ_ALLOC, '0));
        push_random(100);
        wait_drained();

        // wrap at the top of the address space, largest stride and size
        set_cfg(48'hFFFF_FFFF_FF00, 32'hFFFF_FFFF, 16'hFFFF, 9'd256);
        push_random(110);
        wait_drained();

        // zero capacity acts as one, adjacent unit stride
        set_cfg(48'd0, 32'd1, 16'd1, 9'd0);
        push_random(100);
        wait_drained();

        // capacity above the slot count, zero object size
        set_cfg(rand48(), 32'd1, 16'd0, 9'd511);
        push_random(80);
        wait_drained();

        // long receiver hold with no sender idling, block must back up
        set_cfg(48'h4000, 32'd1024, 16'd8, 9'd100);
        no_idle = 1;
        hold_req++;
        push_random(150);
        wait_drained();
        no_idle = 0;

        for (int p = 0; p < 4; p++) begin
            set_cfg(rand48(), 32'($urandom_range(1, 4096)),
                    16'($urandom_range(1, 300)), 9'($urandom_range(1, 300)));
            push_random(70);
            wait_drained();
        end

        repeat (100) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/bmoa_pkg.sv
rtl/bitmap_object_allocator.sv
rtl/bmoa_checker.sv
dv/bitmap_object_allocator_tb.sv
